FILE: design/tdu_pkg.sv
// ----------------------------------------------------------------------------
// tdu_pkg: shared definitions for the two-bit DNA unpacker
// Block table sizes, operation and register codes, and the base letter table.
// ----------------------------------------------------------------------------
package tdu_pkg;

	localparam int N_BLOCK_SLOTS    = 16;
	localparam int MASK_BLOCK_SLOTS = 16;

	localparam int N_CNT_W = $clog2(N_BLOCK_SLOTS + 1);
	localparam int M_CNT_W = $clog2(MASK_BLOCK_SLOTS + 1);
	localparam int N_IDX_W = (N_BLOCK_SLOTS > 1) ? $clog2(N_BLOCK_SLOTS) : 1;
	localparam int M_IDX_W = (MASK_BLOCK_SLOTS > 1) ? $clog2(MASK_BLOCK_SLOTS) : 1;

	localparam logic [7:0] CHAR_N     = 8'h4E;
	localparam logic [7:0] LOWER_MASK = 8'h20;

	typedef enum logic [1:0] {
		OP_LOAD_N    = 2'd0,
		OP_LOAD_MASK = 2'd1,
		OP_BEGIN     = 2'd2,
		OP_DECODE    = 2'd3
	} op_t;

	localparam logic CFG_REGION_START = 1'b0;
	localparam logic CFG_REGION_END   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_NSCAN,
		ST_MSCAN,
		ST_EMIT
	} state_t;

	function automatic logic [7:0] base_letter(input logic [1:0] code);
		logic [7:0] c;
		case (code)
			2'd0: c = 8'h54;
			2'd1: c = 8'h43;
			2'd2: c = 8'h41;
			2'd3: c = 8'h47;
			default: c = 8'h54;
		endcase
		return c;
	endfunction

endpackage

FILE: design/tdu_if.sv
// ----------------------------------------------------------------------------
// tdu_in_if / tdu_out_if: item channels of the two-bit DNA unpacker
// Valid/ready channels carrying the input item and one decoded base.
// ----------------------------------------------------------------------------
interface tdu_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] block_start;
	logic [31:0] block_size;
	logic [7:0]  packed_byte;

	modport source (output valid, op, block_start, block_size, packed_byte, input ready);
	modport sink (input valid, op, block_start, block_size, packed_byte, output ready);
endinterface

interface tdu_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  base_char;
	logic [31:0] base_pos;
	logic        last;
	logic        table_overflow;

	modport source (output valid, base_char, base_pos, last, table_overflow, input ready);
	modport sink (input valid, base_char, base_pos, last, table_overflow, output ready);
endinterface

FILE: design/tdu_range_cmp.sv
// ----------------------------------------------------------------------------
// tdu_range_cmp: shared half-open range compare
// Tells whether a base position lies in [lo, hi), with a 33-bit upper bound.
// ----------------------------------------------------------------------------
module tdu_range_cmp
	import tdu_pkg::*;
(
	input  logic [31:0] pos,
	input  logic [31:0] lo,
	input  logic [32:0] hi,
	output logic        hit
);

	assign hit = (pos >= lo) && ({1'b0, pos} < hi);

endmodule

FILE: design/twobit_dna_unpack_with_masks.sv
// ----------------------------------------------------------------------------
// twobit_dna_unpack_with_masks: packed 2-bit DNA decoder with N and mask blocks
// Load and begin items are taken from idle; positions outside the region are
// skipped. A base inside the region is checked against the filled N slots and
// then the filled mask slots, each scan stopping at its first hit, all through
// one range comparator, and is then emitted.
// Reset clears the slot counts, byte address, overflow flag and region bounds.
// ----------------------------------------------------------------------------
module twobit_dna_unpack_with_masks
	import tdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	tdu_in_if.sink      in_ch,
	tdu_out_if.source   out_ch
);

	logic [31:0] n_start_mem [N_BLOCK_SLOTS];
	logic [32:0] n_end_mem   [N_BLOCK_SLOTS];
	logic [31:0] m_start_mem [MASK_BLOCK_SLOTS];
	logic [32:0] m_end_mem   [MASK_BLOCK_SLOTS];

	state_t               state_q, state_d;
	logic [31:0]          region_start_q, region_end_q;
	logic [N_CNT_W-1:0]   n_used_q, n_used_d;
	logic [M_CNT_W-1:0]   m_used_q, m_used_d;
	logic                 ovf_q, ovf_d;
	logic [29:0]          byte_addr_q, byte_addr_d;
	logic [1:0]           k_q, k_d;
	logic [N_IDX_W-1:0]   n_scan_q, n_scan_d;
	logic [M_IDX_W-1:0]   m_scan_q, m_scan_d;
	logic [7:0]           packed_q, packed_d;
	logic                 n_hit_q, n_hit_d;
	logic                 m_hit_q, m_hit_d;
	logic                 last_q, last_d;
	logic                 n_write, m_write;
	logic [31:0]          n_lo_q, m_lo_q;
	logic [32:0]          n_hi_q, m_hi_q;

	logic [31:0] pos;
	logic [31:0] cmp_lo;
	logic [32:0] cmp_hi;
	logic        cmp_hit;
	logic [1:0]  code;
	logic [7:0]  letter;
	logic        n_scan_done, m_scan_done;

	assign pos    = {byte_addr_q, k_q};
	assign code   = 2'(packed_q >> (3'd6 - {k_q, 1'b0}));

	assign n_scan_done = (N_CNT_W'(n_scan_q) + N_CNT_W'(1)) == n_used_q;
	assign m_scan_done = (M_CNT_W'(m_scan_q) + M_CNT_W'(1)) == m_used_q;

	always_comb begin
		case (state_q)
			ST_NSCAN: begin
				cmp_lo = n_lo_q;
				cmp_hi = n_hi_q;
			end
			ST_MSCAN: begin
				cmp_lo = m_lo_q;
				cmp_hi = m_hi_q;
			end
			default: begin
				cmp_lo = region_start_q;
				cmp_hi = {1'b0, region_end_q};
			end
		endcase
	end

	tdu_range_cmp u_cmp (
		.pos (pos),
		.lo  (cmp_lo),
		.hi  (cmp_hi),
		.hit (cmp_hit)
	);

	always_comb begin
		state_d     = state_q;
		n_used_d    = n_used_q;
		m_used_d    = m_used_q;
		ovf_d       = ovf_q;
		byte_addr_d = byte_addr_q;
		k_d         = k_q;
		n_scan_d    = n_scan_q;
		m_scan_d    = m_scan_q;
		packed_d    = packed_q;
		n_hit_d     = n_hit_q;
		m_hit_d     = m_hit_q;
		last_d      = last_q;
		n_write     = 1'b0;
		m_write     = 1'b0;
		in_ch.ready = 1'b0;
		out_ch.valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					case (in_ch.op)
						OP_LOAD_N: begin
							if (n_used_q < N_CNT_W'(N_BLOCK_SLOTS)) begin
								n_write  = 1'b1;
								n_used_d = n_used_q + N_CNT_W'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
						OP_LOAD_MASK: begin
							if (m_used_q < M_CNT_W'(MASK_BLOCK_SLOTS)) begin
								m_write  = 1'b1;
								m_used_d = m_used_q + M_CNT_W'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
						OP_BEGIN: begin
							n_used_d    = '0;
							m_used_d    = '0;
							ovf_d       = 1'b0;
							byte_addr_d = region_start_q[31:2];
						end
						OP_DECODE: begin
							packed_d = in_ch.packed_byte;
							k_d      = 2'd0;
							state_d  = ST_POS;
						end
						default: ;
					endcase
				end
			end
			ST_POS: begin
				if (cmp_hit) begin
					last_d   = (k_q == 2'd3) || ((pos + 32'd1) == region_end_q);
					n_hit_d  = 1'b0;
					m_hit_d  = 1'b0;
					n_scan_d = '0;
					m_scan_d = '0;
					if (n_used_q != '0) begin
						state_d = ST_NSCAN;
					end else if (m_used_q != '0) begin
						state_d = ST_MSCAN;
					end else begin
						state_d = ST_EMIT;
					end
				end else if (k_q == 2'd3) begin
					byte_addr_d = byte_addr_q + 30'd1;
					state_d     = ST_IDLE;
				end else begin
					k_d = k_q + 2'd1;
				end
			end
			ST_NSCAN: begin
				if (cmp_hit || n_scan_done) begin
					n_hit_d = cmp_hit;
					state_d = (m_used_q != '0) ? ST_MSCAN : ST_EMIT;
				end else begin
					n_scan_d = n_scan_q + N_IDX_W'(1);
				end
			end
			ST_MSCAN: begin
				if (cmp_hit || m_scan_done) begin
					m_hit_d = cmp_hit;
					state_d = ST_EMIT;
				end else begin
					m_scan_d = m_scan_q + M_IDX_W'(1);
				end
			end
			ST_EMIT: begin
				out_ch.valid = 1'b1;
				if (out_ch.ready) begin
					if (last_q) begin
						byte_addr_d = byte_addr_q + 30'd1;
						state_d     = ST_IDLE;
					end else begin
						k_d     = k_q + 2'd1;
						state_d = ST_POS;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			region_start_q <= '0;
			region_end_q   <= '0;
			n_used_q       <= '0;
			m_used_q       <= '0;
			ovf_q          <= 1'b0;
			byte_addr_q    <= '0;
			k_q            <= '0;
			n_scan_q       <= '0;
			m_scan_q       <= '0;
			n_hit_q        <= 1'b0;
			m_hit_q        <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			state_q     <= state_d;
			n_used_q    <= n_used_d;
			m_used_q    <= m_used_d;
			ovf_q       <= ovf_d;
			byte_addr_q <= byte_addr_d;
			k_q         <= k_d;
			n_scan_q    <= n_scan_d;
			m_scan_q    <= m_scan_d;
			n_hit_q     <= n_hit_d;
			m_hit_q     <= m_hit_d;
			last_q      <= last_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_REGION_START: region_start_q <= cfg_data;
					CFG_REGION_END:   region_end_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Table entries are read at the next scan index so the data is ready
	// in the cycle that the index register holds it.
	always_ff @(posedge clk) begin
		packed_q <= packed_d;
		n_lo_q   <= n_start_mem[n_scan_d];
		n_hi_q   <= n_end_mem[n_scan_d];
		m_lo_q   <= m_start_mem[m_scan_d];
		m_hi_q   <= m_end_mem[m_scan_d];
		if (n_write) begin
			n_start_mem[n_used_q[N_IDX_W-1:0]] <= in_ch.block_start;
			n_end_mem[n_used_q[N_IDX_W-1:0]]   <= {1'b0, in_ch.block_start}
				+ {1'b0, in_ch.block_size};
		end
		if (m_write) begin
			m_start_mem[m_used_q[M_IDX_W-1:0]] <= in_ch.block_start;
			m_end_mem[m_used_q[M_IDX_W-1:0]]   <= {1'b0, in_ch.block_start}
				+ {1'b0, in_ch.block_size};
		end
	end

	always_comb begin
		letter = n_hit_q ? CHAR_N : base_letter(code);
		out_ch.base_char      = m_hit_q ? (letter | LOWER_MASK) : letter;
		out_ch.base_pos       = pos;
		out_ch.last           = last_q;
		out_ch.table_overflow = ovf_q;
	end

	// The input side is never open while a base waits at the output.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while a base is pending");

	// The table scans only run over filled slots.
	a_nscan_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NSCAN) |-> (n_used_q != '0))
		else $error("N table scan with no filled slot");

	a_mscan_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MSCAN) |-> (m_used_q != '0))
		else $error("mask table scan with no filled slot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(n_used_q <= N_CNT_W'(N_BLOCK_SLOTS)) && (m_used_q <= M_CNT_W'(MASK_BLOCK_SLOTS)))
		else $error("slot count beyond table size");

	// After the final base of a byte the block takes the next item.
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
		else $error("block not idle after final base of a byte");

endmodule
